>>> rtl/core/djtq_pkg.sv
// Shared widths, request and status codes, and controller interface types for the timer queue.
package djtq_pkg;

    localparam int TIME_W      = 48;
    localparam int DELAY_W     = 32;
    localparam int QID_W       = 8;
    localparam int JID_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 6;
    localparam int MAX_RESULTS = 32;
    localparam int NUM_W       = $clog2(MAX_RESULTS);

    localparam logic [1:0] REQ_RESERVE    = 2'd0;
    localparam logic [1:0] REQ_DISTRIBUTE = 2'd1;
    localparam logic [1:0] REQ_CLEAR      = 2'd2;
    localparam logic [1:0] REQ_NOP        = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                load;
        logic                insert;
        logic                pop;
        logic                clear;
        logic                emit;
        logic [STATUS_W-1:0] res_status;
        logic                res_job;
        logic                res_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic head_due;
        logic next_due;
        logic emit_ok;
    } stat_t;

endpackage

>>> rtl/core/djtq_ctrl.sv
// Controller state machine that sequences reserve, distribute, clear and unused requests.
module djtq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     req_type,
    input  djtq_pkg::stat_t stat,
    output djtq_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESV,
        S_DIST,
        S_CLEAR,
        S_NOP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [djtq_pkg::NUM_W-1:0] num_reg;
    logic [djtq_pkg::NUM_W-1:0] num_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        num_next   = num_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    num_next = '0;
                    unique case (req_type)
                        djtq_pkg::REQ_RESERVE:    state_next = S_RESV;
                        djtq_pkg::REQ_DISTRIBUTE: state_next = S_DIST;
                        djtq_pkg::REQ_CLEAR:      state_next = S_CLEAR;
                        default:                  state_next = S_NOP;
                    endcase
                end
            end
            S_RESV:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.res_last = 1'b1;
                    if (stat.full)
                    begin
                        cmd.res_status = djtq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.insert     = 1'b1;
                        cmd.res_status = djtq_pkg::ST_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DIST:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    if (stat.head_due)
                    begin
                        cmd.pop        = 1'b1;
                        cmd.res_job    = 1'b1;
                        cmd.res_status = djtq_pkg::ST_OK;
                        cmd.res_last   = !stat.next_due ||
                            (num_reg == djtq_pkg::NUM_W'(djtq_pkg::MAX_RESULTS - 1));
                        num_next       = num_reg + 1'b1;
                        if (cmd.res_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.res_status = djtq_pkg::ST_EMPTY;
                        cmd.res_last   = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_CLEAR:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit       = 1'b1;
                    cmd.clear      = 1'b1;
                    cmd.res_status = djtq_pkg::ST_OK;
                    cmd.res_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_NOP:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit       = 1'b1;
                    cmd.res_status = djtq_pkg::ST_OK;
                    cmd.res_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            num_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            num_reg   <= num_next;
        end
    end

endmodule

>>> rtl/core/djtq_datapath.sv
// Sorted job store as a shift array, request registers and the result register.
module djtq_datapath
#(
    parameter int DEPTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  djtq_pkg::cmd_t                    cmd,
    output djtq_pkg::stat_t                   stat,
    input  logic [djtq_pkg::TIME_W-1:0]       current_time,
    input  logic [djtq_pkg::DELAY_W-1:0]      delay_ticks,
    input  logic [djtq_pkg::QID_W-1:0]        queue_id,
    input  logic [djtq_pkg::JID_W-1:0]        job_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [djtq_pkg::STATUS_W-1:0]     status,
    output logic                              job_valid,
    output logic [djtq_pkg::QID_W-1:0]        out_queue_id,
    output logic [djtq_pkg::JID_W-1:0]        out_job_id,
    output logic [djtq_pkg::TIME_W-1:0]       out_deadline,
    output logic [djtq_pkg::COUNT_W-1:0]      pending_count,
    output logic                              has_work,
    output logic                              last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [djtq_pkg::TIME_W-1:0] dl_arr [DEPTH];
    logic [djtq_pkg::QID_W-1:0]  q_arr  [DEPTH];
    logic [djtq_pkg::JID_W-1:0]  j_arr  [DEPTH];

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [djtq_pkg::TIME_W-1:0] now_reg;
    logic [djtq_pkg::TIME_W-1:0] new_dl_reg;
    logic [djtq_pkg::QID_W-1:0]  new_q_reg;
    logic [djtq_pkg::JID_W-1:0]  new_j_reg;
    logic [djtq_pkg::TIME_W:0]   dl_sum;

    logic [DEPTH-1:0]            gt;
    logic [DEPTH-1:0]            prev_gt;
    logic [DEPTH-1:0]            at_pos;

    logic                        out_valid_reg;
    logic [djtq_pkg::STATUS_W-1:0] status_reg;
    logic                        job_valid_reg;
    logic [djtq_pkg::QID_W-1:0]  queue_reg;
    logic [djtq_pkg::JID_W-1:0]  job_reg;
    logic [djtq_pkg::TIME_W-1:0] deadline_reg;
    logic [djtq_pkg::COUNT_W-1:0] pending_reg;
    logic [djtq_pkg::COUNT_W-1:0] pending_next;
    logic [CW+djtq_pkg::COUNT_W-1:0] count_ext;
    logic                        has_work_reg;
    logic                        last_reg;

    assign dl_sum = {1'b0, current_time} +
                    {{(djtq_pkg::TIME_W + 1 - djtq_pkg::DELAY_W){1'b0}}, delay_ticks};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg    <= current_time;
            new_dl_reg <= dl_sum[djtq_pkg::TIME_W] ? '1 : dl_sum[djtq_pkg::TIME_W-1:0];
            new_q_reg  <= queue_id;
            new_j_reg  <= job_id;
        end
    end

    // Live entries later than the new deadline move up one place.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CW'(i) < count_reg) && (dl_arr[i] > new_dl_reg);
        end
        prev_gt[0] = 1'b0;
        for (int i = 1; i < DEPTH; i++)
        begin
            prev_gt[i] = gt[i-1];
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            at_pos[i] = !prev_gt[i] && (gt[i] || (CW'(i) == count_reg));
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        logic [djtq_pkg::TIME_W-1:0] below_dl;
        logic [djtq_pkg::QID_W-1:0]  below_q;
        logic [djtq_pkg::JID_W-1:0]  below_j;
        logic [djtq_pkg::TIME_W-1:0] above_dl;
        logic [djtq_pkg::QID_W-1:0]  above_q;
        logic [djtq_pkg::JID_W-1:0]  above_j;

        if (g == 0)
        begin : g_first
            assign below_dl = dl_arr[g];
            assign below_q  = q_arr[g];
            assign below_j  = j_arr[g];
        end
        else
        begin : g_rest
            assign below_dl = dl_arr[g-1];
            assign below_q  = q_arr[g-1];
            assign below_j  = j_arr[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_top
            assign above_dl = dl_arr[g];
            assign above_q  = q_arr[g];
            assign above_j  = j_arr[g];
        end
        else
        begin : g_inner
            assign above_dl = dl_arr[g+1];
            assign above_q  = q_arr[g+1];
            assign above_j  = j_arr[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.insert)
            begin
                if (prev_gt[g])
                begin
                    dl_arr[g] <= below_dl;
                    q_arr[g]  <= below_q;
                    j_arr[g]  <= below_j;
                end
                else if (at_pos[g])
                begin
                    dl_arr[g] <= new_dl_reg;
                    q_arr[g]  <= new_q_reg;
                    j_arr[g]  <= new_j_reg;
                end
            end
            else if (cmd.pop)
            begin
                dl_arr[g] <= above_dl;
                q_arr[g]  <= above_q;
                j_arr[g]  <= above_j;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_ext    = {{djtq_pkg::COUNT_W{1'b0}}, count_next};
    assign pending_next = count_ext[djtq_pkg::COUNT_W-1:0];

    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.head_due = (count_reg != '0) && (dl_arr[0] <= now_reg);
    assign stat.next_due = (count_reg > CW'(1)) && (dl_arr[1] <= now_reg);
    assign stat.emit_ok  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg    <= cmd.res_status;
            job_valid_reg <= cmd.res_job;
            queue_reg     <= cmd.res_job ? q_arr[0] : '0;
            job_reg       <= cmd.res_job ? j_arr[0] : '0;
            deadline_reg  <= cmd.res_job ? dl_arr[0] : '0;
            pending_reg   <= pending_next;
            has_work_reg  <= |count_next;
            last_reg      <= cmd.res_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign job_valid     = job_valid_reg;
    assign out_queue_id  = queue_reg;
    assign out_job_id    = job_reg;
    assign out_deadline  = deadline_reg;
    assign pending_count = pending_reg;
    assign has_work      = has_work_reg;
    assign last          = last_reg;

endmodule

>>> rtl/core/deadline_job_timer_queue.sv
// Top level of the deadline-ordered job timer queue.
// A reserve, clear or unused request is accepted, then emits its result with any store update.
// A distribute is accepted, then emits one job per cycle while the output is free, set by the
// single head pop of the sorted shift array, or emits a single nothing-due result.
// Results wait in one output register; a full output register stalls the sequence.
// Reset empties the store and the output register; stored payload is not cleared.
module deadline_job_timer_queue
#(
    parameter int DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [47:0] current_time,
    input  logic [31:0] delay_ticks,
    input  logic [7:0]  queue_id,
    input  logic [15:0] job_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        job_valid,
    output logic [7:0]  out_queue_id,
    output logic [15:0] out_job_id,
    output logic [47:0] out_deadline,
    output logic [5:0]  pending_count,
    output logic        has_work,
    output logic        last
);

    djtq_pkg::cmd_t  cmd;
    djtq_pkg::stat_t stat;

    djtq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    djtq_datapath
    #(
        .DEPTH (DEPTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .current_time  (current_time),
        .delay_ticks   (delay_ticks),
        .queue_id      (queue_id),
        .job_id        (job_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .job_valid     (job_valid),
        .out_queue_id  (out_queue_id),
        .out_job_id    (out_job_id),
        .out_deadline  (out_deadline),
        .pending_count (pending_count),
        .has_work      (has_work),
        .last          (last)
    );

endmodule
